// ===== rtl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
package ple_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int DATA_W_DEF = 32;

  typedef enum logic [2:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_DUMP      = 3'd6
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_FIN,
    S_DEL,
    S_DUMP
  } state_t;

  typedef struct packed {
    op_t                opcode;
    logic signed [31:0] value;
    logic [6:0]         position;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] element;
    logic               has_element;
    logic [6:0]         entry_total;
    logic               last_result;
  } out_word_t;

endpackage

// ===== rtl/ple_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/positional_list_engine.sv =====
// Positional list engine: ordered list of signed values held in one RAM.
//
// Keeps up to DEPTH values in order, front at address 0, plus a count. Every
// insert or delete returns one status word in the cycle after it is taken;
// rejected operations change nothing. Elements live in a single RAM with one
// write and one read port, so positional work moves one cell per cycle: an
// insert at the back is written when taken; any other insert moves cells
// from its position up, back first (S_INS), then writes the value (S_INS_FIN).
// A delete at the back only lowers the count; others move the cells above
// it down (S_DEL). A dump reads the front cell, then streams one word per
// cycle while the output is not stalled; an empty list dumps a single word
// with status empty. A new input is taken only once the previous operation's
// memory work is finished and the output register is free or being emptied.
module positional_list_engine #(
  parameter int DEPTH  = ple_pkg::DEPTH_DEF,
  parameter int DATA_W = ple_pkg::DATA_W_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ple_pkg::in_word_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ple_pkg::out_word_t  out_data
);

  import ple_pkg::*;

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMP_W = ((CW > 7) ? CW : 7) + 1;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  out_word_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic              out_free, in_acc;
  logic [CMP_W-1:0]  pos_x, cnt_x;
  logic [AW-1:0]     pos_idx;
  logic [DATA_W-1:0] in_val;

  ple_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == S_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pos_x   = CMP_W'(in_data.position);
  assign cnt_x   = CMP_W'(count_r);
  assign pos_idx = AW'(pos_x - CMP_W'(1));
  assign in_val  = DATA_W'(in_data.value);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    status_t       stat;
    logic [AW-1:0] idx;
    logic          respond;

    stat          = ST_OK;
    idx           = '0;
    respond       = 1'b0;
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_waddr     = ptr_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = ptr_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          respond = 1'b1;
          if (in_data.opcode inside {OP_INS_FRONT, OP_INS_BACK, OP_INS_AT}) begin
            if (in_data.opcode == OP_INS_AT &&
                (pos_x == '0 || pos_x > cnt_x + CMP_W'(1))) begin
              stat = ST_BAD_POS;
            end else if (count_r == CW'(DEPTH)) begin
              stat = ST_FULL;
            end else begin
              case (in_data.opcode)
                OP_INS_FRONT: idx = '0;
                OP_INS_BACK:  idx = AW'(count_r);
                default:      idx = pos_idx;
              endcase
              count_nxt = count_r + CW'(1);
              if (CW'(idx) == count_r) begin
                ram_we    = 1'b1;
                ram_waddr = idx;
                ram_wdata = in_val;
              end else begin
                // move cells up from the back, new value goes in last
                ram_re    = 1'b1;
                ram_raddr = AW'(count_r - CW'(1));
                ptr_nxt   = AW'(count_r - CW'(1));
                idx_nxt   = idx;
                val_nxt   = in_val;
                state_nxt = S_INS;
              end
            end
          end else if (in_data.opcode inside {OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT}) begin
            if (in_data.opcode == OP_DEL_AT && (pos_x == '0 || pos_x > cnt_x)) begin
              stat = ST_BAD_POS;
            end else if (count_r == '0) begin
              stat = ST_EMPTY;
            end else begin
              case (in_data.opcode)
                OP_DEL_FRONT: idx = '0;
                OP_DEL_BACK:  idx = AW'(count_r - CW'(1));
                default:      idx = pos_idx;
              endcase
              count_nxt = count_r - CW'(1);
              if (CW'(idx) != count_r - CW'(1)) begin
                ram_re    = 1'b1;
                ram_raddr = idx + AW'(1);
                ptr_nxt   = idx + AW'(1);
                state_nxt = S_DEL;
              end
            end
          end else if (in_data.opcode == OP_DUMP) begin
            if (count_r == '0) begin
              stat = ST_EMPTY;
            end else begin
              respond   = 1'b0;
              ram_re    = 1'b1;
              ram_raddr = '0;
              ptr_nxt   = '0;
              state_nxt = S_DUMP;
            end
          end
          if (respond) begin
            out_nxt.status      = stat;
            out_nxt.element     = '0;
            out_nxt.has_element = 1'b0;
            out_nxt.entry_total = 7'(count_nxt);
            out_nxt.last_result = 1'b1;
            out_valid_nxt       = 1'b1;
          end
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r + AW'(1);
        ram_wdata = ram_rdata;
        if (ptr_r == idx_r) begin
          state_nxt = S_INS_FIN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r - AW'(1);
          ptr_nxt   = ptr_r - AW'(1);
        end
      end

      S_INS_FIN: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = val_r;
        state_nxt = S_IDLE;
      end

      S_DEL: begin
        ram_we    = 1'b1;
        ram_waddr = ptr_r - AW'(1);
        ram_wdata = ram_rdata;
        // count already holds the new total, equal to the last source index
        if (CW'(ptr_r) == count_r) begin
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r + AW'(1);
          ptr_nxt   = ptr_r + AW'(1);
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_nxt.status      = ST_OK;
          out_nxt.element     = 32'($signed(ram_rdata));
          out_nxt.has_element = 1'b1;
          out_nxt.entry_total = 7'(count_r);
          out_nxt.last_result = (CW'(ptr_r) + CW'(1) == count_r);
          out_valid_nxt       = 1'b1;
          if (CW'(ptr_r) + CW'(1) == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ptr_r + AW'(1);
            ptr_nxt   = ptr_r + AW'(1);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_dump_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DUMP |-> !ram_we)
    else $error("memory written during dump");

  a_ins_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INS |-> idx_r <= ptr_r && CW'(ptr_r) < count_r)
    else $error("insert shift pointer out of range");

  a_del_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DEL |-> ptr_r != '0 && CW'(ptr_r) <= count_r)
    else $error("delete shift pointer out of range");

  a_dump_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.has_element |-> out_r.status == ST_OK)
    else $error("dumped word with error status");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for positional_list_engine: directed and random traffic against a list predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_DEPTH  = ple_pkg::DEPTH_DEF;
  localparam int RAND_ITEMS  = 430;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_WAIT  = 100;
  localparam int MAX_POS     = 65;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t           pending_words[$];
  out_word_t          expected_words[$];
  logic signed [31:0] list_vals[$];

  int plan_cnt = 0;
  int rand_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;

  positional_list_engine i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic void expect_word(status_t st, logic signed [31:0] elem, logic has,
                                      logic last);
    out_word_t w;
    w.status      = st;
    w.element     = elem;
    w.has_element = has;
    w.entry_total = 7'(list_vals.size());
    w.last_result = last;
    expected_words.push_back(w);
  endfunction

  // List behavior: update the shadow list and queue the words this op returns
  function automatic void apply_list_op(in_word_t w);
    int cnt;
    int pos;
    cnt = list_vals.size();
    pos = int'(w.position);
    case (w.opcode)
      OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
        if (w.opcode == OP_INS_AT && (pos < 1 || pos > cnt + 1)) begin
          expect_word(ST_BAD_POS, '0, 1'b0, 1'b1);
        end else if (cnt >= LIST_DEPTH) begin
          expect_word(ST_FULL, '0, 1'b0, 1'b1);
        end else begin
          if (w.opcode == OP_INS_FRONT) list_vals.push_front(w.value);
          else if (w.opcode == OP_INS_BACK) list_vals.push_back(w.value);
          else list_vals.insert(pos - 1, w.value);
          expect_word(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_DEL_FRONT, OP_DEL_BACK: begin
        if (cnt == 0) begin
          expect_word(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          if (w.opcode == OP_DEL_FRONT) list_vals.delete(0);
          else list_vals.delete(cnt - 1);
          expect_word(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_DEL_AT: begin
        if (pos < 1 || pos > cnt) begin
          expect_word(ST_BAD_POS, '0, 1'b0, 1'b1);
        end else begin
          list_vals.delete(pos - 1);
          expect_word(ST_OK, '0, 1'b0, 1'b1);
        end
      end
      OP_DUMP: begin
        if (cnt == 0) begin
          expect_word(ST_EMPTY, '0, 1'b0, 1'b1);
        end else begin
          for (int i = 0; i < cnt; i++)
            expect_word(ST_OK, list_vals[i], 1'b1, i == cnt - 1);
        end
      end
      default: expect_word(ST_OK, '0, 1'b0, 1'b1);
    endcase
  endfunction

  // Queue one word and track the count it should leave, to steer positions
  function automatic void add(op_t op, logic [31:0] val, logic [6:0] pos);
    in_word_t w;
    w.opcode   = op;
    w.value    = val;
    w.position = pos;
    pending_words.push_back(w);
    case (op)
      OP_INS_FRONT, OP_INS_BACK: if (plan_cnt < LIST_DEPTH) plan_cnt++;
      OP_INS_AT:
        if (pos >= 1 && pos <= plan_cnt + 1 && plan_cnt < LIST_DEPTH) plan_cnt++;
      OP_DEL_FRONT, OP_DEL_BACK: if (plan_cnt > 0) plan_cnt--;
      OP_DEL_AT: if (pos >= 1 && pos <= plan_cnt) plan_cnt--;
      default: ;
    endcase
  endfunction

  function automatic void plan_random(int unsigned ins_pct, int unsigned dump_pct);
    int unsigned r;
    op_t         op;
    logic [31:0] val;
    logic [6:0]  pos;
    r = $urandom_range(0, 99);
    if (r < dump_pct) op = OP_DUMP;
    else if (r < dump_pct + ins_pct) op = op_t'($urandom_range(0, 2));
    else op = op_t'($urandom_range(3, 5));
    case ($urandom_range(0, 9))
      0: val = 32'h8000_0000;
      1: val = 32'h7fff_ffff;
      2: val = 32'h0000_0000;
      3: val = 32'hffff_ffff;
      default: val = $urandom();
    endcase
    // mostly legal positions, some noise across the whole range
    if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, MAX_POS));
    else if (op == OP_INS_AT) pos = 7'($urandom_range(1, plan_cnt + 1));
    else if (op == OP_DEL_AT && plan_cnt > 0) pos = 7'($urandom_range(1, plan_cnt));
    else pos = 7'($urandom_range(0, MAX_POS));
    add(op, val, pos);
    rand_cnt++;
  endfunction

  // Sender: bursts of words separated by random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall !== 1'b0)) begin
      if (in_valid) apply_list_op(in_data);
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          case ($urandom_range(0, 9))
            0, 1, 2: gap_left = 0;
            3:       gap_left = $urandom_range(10, 30);
            default: gap_left = $urandom_range(1, 4);
          endcase
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: check each word taken, stall on a changing pattern
  int        stall_mode = 0;
  int        mode_left = 0;
  out_word_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_data));
        end else begin
          want = expected_words.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      out_data.status, want.status));
          if (out_data.element !== want.element)
            report_mismatch($sformatf("element got %h want %h",
                                      out_data.element, want.element));
          if (out_data.has_element !== want.has_element)
            report_mismatch($sformatf("has_element got %b want %b",
                                      out_data.has_element, want.has_element));
          if (out_data.entry_total !== want.entry_total)
            report_mismatch($sformatf("entry_total got %0d want %0d",
                                      out_data.entry_total, want.entry_total));
          if (out_data.last_result !== want.last_result)
            report_mismatch($sformatf("last_result got %b want %b",
                                      out_data.last_result, want.last_result));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 9) < 7);
        default: out_stall <= ((mode_left % 8) < 3);
      endcase
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("positional_list_engine: mismatch");
    $finish;
  end

  initial begin
    // rejections on an empty list
    add(OP_DUMP, 32'h0, 7'd0);
    add(OP_DEL_FRONT, 32'h0, 7'd0);
    add(OP_DEL_BACK, 32'h0, 7'd0);
    add(OP_DEL_AT, 32'h0, 7'd1);
    add(OP_INS_AT, 32'h5, 7'd0);
    add(OP_INS_AT, 32'h5, 7'd2);
    // value extremes, positional insert at both ends
    add(OP_INS_AT, 32'h8000_0000, 7'd1);
    add(OP_INS_FRONT, 32'h7fff_ffff, 7'd0);
    add(OP_INS_BACK, 32'hffff_ffff, 7'd65);
    add(OP_INS_AT, 32'h0, 7'd2);
    add(OP_INS_AT, 32'h5555_5555, 7'd5);
    add(OP_INS_AT, 32'haaaa_aaaa, 7'd7);
    add(OP_DUMP, 32'h0, 7'd0);
    add(OP_DEL_AT, 32'h0, 7'd3);
    add(OP_DEL_AT, 32'h0, 7'd0);
    add(OP_DEL_AT, 32'h0, 7'd65);
    add(OP_DEL_AT, 32'h0, 7'd4);
    add(OP_DEL_FRONT, 32'h0, 7'd0);
    add(OP_DEL_BACK, 32'h0, 7'd0);
    add(OP_DUMP, 32'h0, 7'd0);
    add(OP_DEL_AT, 32'h0, 7'd1);
    add(OP_DUMP, 32'h0, 7'd0);

    // fill to the limit, push inserts against it, dump a full list, drain
    while (plan_cnt < LIST_DEPTH) plan_random(90, 2);
    repeat (10) plan_random(100, 0);
    add(OP_DUMP, 32'h0, 7'd0);
    while (plan_cnt > 0) plan_random(10, 2);
    repeat (5) plan_random(0, 0);
    while (rand_cnt < RAND_ITEMS) begin
      int unsigned ins_pct;
      ins_pct = $urandom_range(20, 80);
      repeat ($urandom_range(20, 60)) begin
        if (rand_cnt < RAND_ITEMS) plan_random(ins_pct, 5);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("positional_list_engine: match");
    end else begin
      $display("positional_list_engine: mismatch");
    end
    $finish;
  end

endmodule
